FILE: hw/rtl/bcp_pkg.sv
package bcp_pkg;

	localparam int MoveW  = 16;
	localparam int ScoreW = 32;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 31;

	localparam logic [CfgIdxW-1:0] RegMaxMoves = 2'd0;
	localparam logic [CfgIdxW-1:0] RegScoreDiff = 2'd1;
	localparam logic [CfgIdxW-1:0] RegBothCrit = 2'd2;

	typedef struct packed {
		logic [MoveW-1:0] move;
		logic             none;
		logic             last;
	} result_t;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} bstate_t;

endpackage

FILE: hw/rtl/beam_cutoff_pruner.sv
// Score-margin and top-k pruner. Candidates are pushed one per cycle, while
// full is low, into a sorted insertion chain (ties stay in arrival order); the
// push with last_item closes the set, and full stays high until the set has
// been emitted. The back end then shifts the chain head out once per cycle,
// best first, while the result queue has room, and decides for each position
// whether it is kept; the kept moves form a prefix, so every position after
// the first dropped one is dropped too. Dropped moves leave best to worst
// through a two-entry result queue; a set that keeps everything gives one
// result with none_removed. A set holds full high while its stored candidates
// are shifted out, and longer while the result queue is full. Pushes beyond
// MAX_CHILDREN are ignored except for their last_item mark.
module beam_cutoff_pruner import bcp_pkg::*; #(
	parameter int MAX_CHILDREN = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [MoveW-1:0]         move_code,
	input  logic signed [ScoreW-1:0] score,
	input  logic                     white_to_move,
	input  logic                     last_item,
	output logic                     empty,
	input  logic                     pop,
	output logic [MoveW-1:0]         removed_move,
	output logic                     none_removed,
	output logic                     last_result,
	input  logic                     cfg_we,
	input  logic [CfgIdxW-1:0]       cfg_idx,
	input  logic [CfgDataW-1:0]      cfg_data
);

	localparam int CW = $clog2(MAX_CHILDREN + 1);

	logic [6:0]               max_moves_q;
	logic [30:0]              score_diff_q;
	logic                     both_q;
	bstate_t                  st_q, st_d;
	logic [CW-1:0]            cnt, idx_q;
	logic                     side, ins, shift, clr, qfull, qwr;
	logic                     in_top, in_margin, keep_it, at_last;
	logic [MoveW-1:0]         hmv;
	logic signed [ScoreW-1:0] hsc, best_q, best;
	logic signed [ScoreW+1:0] score_gap;
	result_t                  qd, qo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_moves_q  <= 7'd8;
			score_diff_q <= 31'd2560;
			both_q       <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegMaxMoves:  max_moves_q <= cfg_data[6:0];
				RegScoreDiff: score_diff_q <= cfg_data;
				RegBothCrit:  both_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign ins = push && !full && st_q == ST_LOAD && cnt < CW'(MAX_CHILDREN);
	assign full = st_q != ST_LOAD;

	// head of the set is the best; its distance is zero
	assign best = (idx_q == '0) ? hsc : best_q;
	assign score_gap = side ? ({{2{best[ScoreW-1]}}, best} - {{2{hsc[ScoreW-1]}}, hsc})
	                        : ({{2{hsc[ScoreW-1]}}, hsc} - {{2{best[ScoreW-1]}}, best});

	assign in_margin = score_gap < $signed({3'b0, score_diff_q});
	assign in_top    = {{7{1'b0}}, idx_q} < {{CW{1'b0}}, max_moves_q};
	assign keep_it   = both_q ? (in_top && in_margin) : (in_top || in_margin);
	assign at_last   = idx_q == cnt - 1'b1;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_LOAD: if (push && !full && last_item) st_d = ST_EMIT;
			ST_EMIT: if (!qfull && at_last) st_d = ST_LOAD;
			default: st_d = ST_LOAD;
		endcase
	end

	always_comb begin
		shift = 1'b0;
		qwr   = 1'b0;
		qd    = '0;
		clr   = 1'b0;
		case (st_q)
			ST_EMIT: begin
				if (!qfull) begin
					shift   = 1'b1;
					qwr     = !keep_it || at_last;
					qd.move = keep_it ? '0 : hmv;
					qd.none = keep_it;
					qd.last = at_last;
					clr     = at_last;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_LOAD;
			idx_q  <= '0;
			best_q <= '0;
		end else begin
			st_q <= st_d;
			if (clr)
				idx_q <= '0;
			else if (shift)
				idx_q <= idx_q + 1'b1;
			if (shift && idx_q == '0)
				best_q <= hsc;
		end
	end

	bcp_sort_chain #(.N(MAX_CHILDREN), .CW(CW)) u_chain (
		.clk, .arst_n, .ins, .clr,
		.move_in(move_code), .score_in(score), .side_in(white_to_move),
		.shift,
		.count(cnt), .side,
		.head_move(hmv), .head_score(hsc)
	);

	bcp_result_fifo u_fifo (
		.clk, .arst_n, .wr(qwr), .din(qd), .rd(pop && !empty),
		.full(qfull), .empty, .dout(qo)
	);

	assign removed_move = qo.move;
	assign none_removed = qo.none;
	assign last_result  = qo.last;

endmodule

FILE: hw/rtl/bcp_sort_chain.sv
// Front part: insertion chain, one slot per candidate, kept best first.
module bcp_sort_chain import bcp_pkg::*; #(
	parameter int N  = 64,
	parameter int CW = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     ins,
	input  logic                     clr,
	input  logic [MoveW-1:0]         move_in,
	input  logic signed [ScoreW-1:0] score_in,
	input  logic                     side_in,
	input  logic                     shift,
	output logic [CW-1:0]            count,
	output logic                     side,
	output logic [MoveW-1:0]         head_move,
	output logic signed [ScoreW-1:0] head_score
);

	logic [MoveW-1:0]         mv_q [N];
	logic signed [ScoreW-1:0] sc_q [N];
	logic [N-1:0]             vld_q;
	logic                     side_q;
	logic [CW-1:0]            cnt_q;
	logic                     sd;
	logic [N-1:0]             bt;

	assign sd = (cnt_q == '0) ? side_in : side_q;

	always_comb begin
		for (int k = 0; k < N; k++)
			bt[k] = !vld_q[k] || (sd ? (score_in > sc_q[k]) : (score_in < sc_q[k]));
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			if (ins) begin
				if (bt[k]) begin
					if (k == 0 || !bt[(k == 0) ? 0 : k-1]) begin
						mv_q[k] <= move_in;
						sc_q[k] <= score_in;
					end else begin
						mv_q[k] <= mv_q[(k == 0) ? 0 : k-1];
						sc_q[k] <= sc_q[(k == 0) ? 0 : k-1];
					end
				end
			end else if (shift && k < N-1) begin
				mv_q[k] <= mv_q[(k < N-1) ? k+1 : k];
				sc_q[k] <= sc_q[(k < N-1) ? k+1 : k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			side_q <= 1'b0;
			cnt_q  <= '0;
		end else if (clr) begin
			vld_q <= '0;
			cnt_q <= '0;
		end else if (ins) begin
			vld_q <= {vld_q[N-2:0], 1'b1};
			cnt_q <= cnt_q + 1'b1;
			side_q <= sd;
		end else if (shift) begin
			vld_q <= {1'b0, vld_q[N-1:1]};
		end
	end

	assign count      = cnt_q;
	assign side       = side_q;
	assign head_move  = mv_q[0];
	assign head_score = sc_q[0];

endmodule

FILE: hw/rtl/bcp_result_fifo.sv
module bcp_result_fifo import bcp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  result_t din,
	input  logic    rd,
	output logic    full,
	output logic    empty,
	output result_t dout
);

	result_t    mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] n_q;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q  <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			n_q <= n_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	assign full  = n_q == 2'd2;
	assign empty = n_q == 2'd0;
	assign dout  = mem_q[rp_q];

endmodule
